[rtl/core/assert_macros.svh]
// Assertion macros used by the log cleaning candidate table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under a synchronous active-low reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication under a synchronous active-low reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/lcct_pkg.sv]
// Package: sizes, codes and types of the log cleaning candidate table.
package lcct_pkg;

    localparam int TABLE_ENTRIES   = 64;
    localparam int LOG_NUMBER_BITS = 16;
    localparam int NUMBER_W        = 16;
    localparam int COUNT_W         = 48;
    localparam int KIND_W          = 3;
    localparam int STATUS_W        = 2;

    localparam int ROW_LANES = 8;
    localparam int LANE_W    = $clog2(ROW_LANES);
    localparam int ROWS      = (TABLE_ENTRIES + ROW_LANES - 1) / ROW_LANES;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MEM_ROWS  = 1 << ROW_W;
    localparam int SLOTS     = MEM_ROWS * ROW_LANES;
    localparam int SLOT_W    = ROW_W + LANE_W;

    localparam logic [ROW_W-1:0]   LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 64;
    localparam int REG_SEL_BIT = 3;

    localparam logic             REG_THRESHOLD   = 1'b0;
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(1);

    localparam logic [KIND_W-1:0] KIND_ADD     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SET_CUR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DROP    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RESTORE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_CNT_RD,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic                       v;
        logic [SLOT_W-1:0]          slot;
        logic [LOG_NUMBER_BITS-1:0] num;
    } t_pick;

endpackage

[rtl/core/log_cleaning_candidate_table.sv]
// Log cleaning candidate table: keyed table of log entries with drop counts and marks.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+-------------------------------------
//  command | in        | start, busy (take: start&!busy) | i_kind, i_log_number, i_count_value
//  result  | out       | o_done, one cycle, no stall  | o_hit, o_status, o_drop_count,
//          |           |                              | o_candidate_valid, o_candidate_number
//  config  | in        | APB, pready tied high        | drop threshold at byte address 0
//
//  An item is taken in the idle state; the scan state then sweeps each memory row of
//  eight log numbers for key, free slot and marked entries, a drain state takes the last row,
//  then a count memory read state and a read-modify-write state that also registers the result.
//  busy falls as o_done rises, so the next item may be taken in the result cycle.
//  Reset is synchronous; valid bits and marks clear at once, so no clearing pass is needed.
`include "assert_macros.svh"

module log_cleaning_candidate_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [lcct_pkg::KIND_W-1:0]       i_kind,
    input  logic [lcct_pkg::NUMBER_W-1:0]     i_log_number,
    input  logic [lcct_pkg::COUNT_W-1:0]      i_count_value,
    output logic                              o_done,
    output logic                              o_hit,
    output logic [lcct_pkg::STATUS_W-1:0]     o_status,
    output logic [lcct_pkg::COUNT_W-1:0]      o_drop_count,
    output logic                              o_candidate_valid,
    output logic [lcct_pkg::NUMBER_W-1:0]     o_candidate_number,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lcct_pkg::PADDR_W-1:0]      paddr,
    input  logic [lcct_pkg::PDATA_W-1:0]      pwdata,
    output logic [lcct_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam int LNB = lcct_pkg::LOG_NUMBER_BITS;

    lcct_pkg::t_state r_state, n_state;

    logic [lcct_pkg::SLOTS-1:0]   r_valid;
    logic [lcct_pkg::SLOTS-1:0]   r_mark;
    logic [LNB-1:0]               r_current;
    logic [lcct_pkg::COUNT_W-1:0] r_threshold;
    logic                         r_done;
    logic                         r_rd_v;

    logic [lcct_pkg::KIND_W-1:0]  r_kind;
    logic [LNB-1:0]               r_num;
    logic [lcct_pkg::COUNT_W-1:0] r_val;
    logic [lcct_pkg::ROW_W-1:0]   r_row;
    logic [lcct_pkg::ROW_W-1:0]   r_rd_row;
    logic                         r_found;
    logic [lcct_pkg::SLOT_W-1:0]  r_slot;
    logic                         r_free_v;
    logic [lcct_pkg::SLOT_W-1:0]  r_free_slot;
    lcct_pkg::t_pick              r_c1, r_c2;

    logic [lcct_pkg::ROW_LANES-1:0][LNB-1:0] log_mem [lcct_pkg::MEM_ROWS];
    logic [lcct_pkg::ROW_LANES-1:0][LNB-1:0] r_log_row;
    logic [lcct_pkg::COUNT_W-1:0]            cnt_mem [lcct_pkg::SLOTS];
    logic [lcct_pkg::COUNT_W-1:0]            r_cnt_rd;

    logic                         s_match_v, s_free_v;
    logic [lcct_pkg::SLOT_W-1:0]  s_match_slot, s_free_slot;
    lcct_pkg::t_pick              s_p1, s_p2;

    logic                         e_exec, e_add, e_set_cur, e_upd, e_remove, e_mark;
    logic [lcct_pkg::STATUS_W-1:0] e_status;
    logic [lcct_pkg::COUNT_W-1:0] e_cnt, e_newc, e_inc;
    lcct_pkg::t_pick              e_cand;

    logic cfg_wr;

    assign cfg_wr = psel && penable && pwrite
                    && (paddr[lcct_pkg::REG_SEL_BIT] == lcct_pkg::REG_THRESHOLD);
    assign pready = 1'b1;
    assign prdata = (paddr[lcct_pkg::REG_SEL_BIT] == lcct_pkg::REG_THRESHOLD)
                    ? lcct_pkg::PDATA_W'(r_threshold) : '0;

    always_comb begin
        n_state = r_state;
        busy    = (r_state != lcct_pkg::ST_IDLE);
        case (r_state)
            lcct_pkg::ST_IDLE: begin
                if (start) n_state = lcct_pkg::ST_SCAN;
            end
            lcct_pkg::ST_SCAN: begin
                if (r_row == lcct_pkg::LAST_ROW) n_state = lcct_pkg::ST_DRAIN;
            end
            lcct_pkg::ST_DRAIN:  n_state = lcct_pkg::ST_CNT_RD;
            lcct_pkg::ST_CNT_RD: n_state = lcct_pkg::ST_EXEC;
            lcct_pkg::ST_EXEC:   n_state = lcct_pkg::ST_IDLE;
            default:             n_state = lcct_pkg::ST_IDLE;
        endcase
    end

    // one row of eight slots: key match, lowest free slot, two lowest marked slots
    always_comb begin
        logic [lcct_pkg::SLOT_W-1:0] sl;
        sl           = '0;
        s_match_v    = 1'b0;
        s_match_slot = '0;
        s_free_v     = 1'b0;
        s_free_slot  = '0;
        s_p1         = '0;
        s_p2         = '0;
        for (int l = 0; l < lcct_pkg::ROW_LANES; l++) begin
            sl = {r_rd_row, lcct_pkg::LANE_W'(l)};
            if (r_valid[sl] && (r_log_row[l] == r_num) && !s_match_v) begin
                s_match_v    = 1'b1;
                s_match_slot = sl;
            end
            if (!r_valid[sl] && !s_free_v
                && ({1'b0, sl} < (lcct_pkg::SLOT_W+1)'(lcct_pkg::TABLE_ENTRIES))) begin
                s_free_v    = 1'b1;
                s_free_slot = sl;
            end
            if (r_valid[sl] && r_mark[sl]) begin
                if (!s_p1.v) begin
                    s_p1.v    = 1'b1;
                    s_p1.slot = sl;
                    s_p1.num  = r_log_row[l];
                end else if (!s_p2.v) begin
                    s_p2.v    = 1'b1;
                    s_p2.slot = sl;
                    s_p2.num  = r_log_row[l];
                end
            end
        end
    end

    // read-modify-write of the found entry, add into the free slot, status and next candidate
    always_comb begin
        e_exec    = (r_state == lcct_pkg::ST_EXEC);
        e_add     = 1'b0;
        e_set_cur = 1'b0;
        e_upd     = 1'b0;
        e_remove  = 1'b0;
        e_status  = lcct_pkg::ST_OK;
        e_cnt     = '0;
        e_inc     = (r_cnt_rd == lcct_pkg::COUNT_MAX) ? r_cnt_rd
                    : r_cnt_rd + lcct_pkg::COUNT_W'(1);
        e_newc    = r_val;
        case (r_kind)
            lcct_pkg::KIND_ADD: begin
                if (r_found) begin
                    e_status = lcct_pkg::ST_DUPLICATE;
                    e_cnt    = r_cnt_rd;
                end else if (!r_free_v) begin
                    e_status = lcct_pkg::ST_FULL;
                end else begin
                    e_add = 1'b1;
                end
            end
            lcct_pkg::KIND_SET_CUR: begin
                e_set_cur = 1'b1;
                if (r_found) e_cnt = r_cnt_rd;
            end
            lcct_pkg::KIND_DROP: begin
                e_newc = e_inc;
                if (r_found) begin
                    e_upd = 1'b1;
                    e_cnt = e_inc;
                end else begin
                    e_status = lcct_pkg::ST_NOT_FOUND;
                end
            end
            lcct_pkg::KIND_RESTORE: begin
                if (r_found) begin
                    e_upd = 1'b1;
                    e_cnt = r_val;
                end else begin
                    e_status = lcct_pkg::ST_NOT_FOUND;
                end
            end
            lcct_pkg::KIND_REMOVE: begin
                if (r_found) e_remove = 1'b1;
                else         e_status = lcct_pkg::ST_NOT_FOUND;
            end
            default: begin
                if (r_found) e_cnt = r_cnt_rd;
                else         e_status = lcct_pkg::ST_NOT_FOUND;
            end
        endcase
        e_mark = e_upd && (e_newc >= r_threshold) && (r_num != r_current);

        e_cand = r_c1;
        if (e_mark && (!r_c1.v || (r_slot < r_c1.slot))) begin
            e_cand.v    = 1'b1;
            e_cand.slot = r_slot;
            e_cand.num  = r_num;
        end else if (e_remove && r_c1.v && (r_c1.slot == r_slot)) begin
            e_cand = r_c2;
        end
        if (!e_cand.v) e_cand.num = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcct_pkg::ST_IDLE;
            r_valid     <= '0;
            r_mark      <= '0;
            r_current   <= '0;
            r_threshold <= lcct_pkg::THRESHOLD_RESET;
            r_done      <= 1'b0;
            r_rd_v      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= e_exec;
            r_rd_v  <= (r_state == lcct_pkg::ST_SCAN);
            if (cfg_wr) r_threshold <= pwdata[lcct_pkg::COUNT_W-1:0];
            if (e_exec) begin
                if (e_add) begin
                    r_valid[r_free_slot] <= 1'b1;
                    r_mark[r_free_slot]  <= 1'b0;
                end
                if (e_add || e_set_cur) r_current <= r_num;
                if (e_mark) r_mark[r_slot] <= 1'b1;
                if (e_remove) begin
                    r_valid[r_slot] <= 1'b0;
                    r_mark[r_slot]  <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_kind   <= i_kind;
            r_num    <= i_log_number[LNB-1:0];
            r_val    <= i_count_value;
            r_row    <= '0;
            r_found  <= 1'b0;
            r_free_v <= 1'b0;
            r_c1.v   <= 1'b0;
            r_c2.v   <= 1'b0;
        end
        if (r_state == lcct_pkg::ST_SCAN) begin
            r_rd_row <= r_row;
            r_row    <= r_row + lcct_pkg::ROW_W'(1);
        end
        if (r_rd_v) begin
            if (!r_found && s_match_v) begin
                r_found <= 1'b1;
                r_slot  <= s_match_slot;
            end
            if (!r_free_v && s_free_v) begin
                r_free_v    <= 1'b1;
                r_free_slot <= s_free_slot;
            end
            if (!r_c1.v) begin
                r_c1 <= s_p1;
                r_c2 <= s_p2;
            end else if (!r_c2.v && s_p1.v) begin
                r_c2 <= s_p1;
            end
        end
        if (e_exec) begin
            o_hit              <= r_found;
            o_status           <= e_status;
            o_drop_count       <= e_cnt;
            o_candidate_valid  <= e_cand.v;
            o_candidate_number <= lcct_pkg::NUMBER_W'(e_cand.num);
        end
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (r_state == lcct_pkg::ST_SCAN) r_log_row <= log_mem[r_row];
        if (e_exec && e_add)
            log_mem[r_free_slot[lcct_pkg::SLOT_W-1:lcct_pkg::LANE_W]]
                   [r_free_slot[lcct_pkg::LANE_W-1:0]] <= r_num;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lcct_pkg::ST_CNT_RD) r_cnt_rd <= cnt_mem[r_slot];
        if (e_exec && e_add)  cnt_mem[r_free_slot] <= '0;
        if (e_exec && e_upd)  cnt_mem[r_slot]      <= e_newc;
    end

    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_IMPLY(a_cand_zero, i_clk, i_rst_n, o_done && !o_candidate_valid, o_candidate_number == '0)
    `ASSERT_IMPLY(a_free_slot, i_clk, i_rst_n, e_exec && r_free_v, !r_valid[r_free_slot])
    `ASSERT_IMPLY(a_mark_valid, i_clk, i_rst_n, 1'b1, (r_mark & ~r_valid) == '0)

endmodule

[dv/testbench.sv]
// Testbench for the log cleaning candidate table: directed and random items against a model.
`timescale 1ns / 1ps

module testbench;

    localparam logic [lcct_pkg::KIND_W-1:0]  KIND_LOOKUP    = 3'd5;
    localparam logic [lcct_pkg::KIND_W-1:0]  KIND_SPARE_LO  = 3'd6;
    localparam logic [lcct_pkg::KIND_W-1:0]  KIND_SPARE_HI  = 3'd7;
    localparam logic [lcct_pkg::PADDR_W-1:0] THRESHOLD_ADDR =
        lcct_pkg::PADDR_W'(8 * int'(lcct_pkg::REG_THRESHOLD));
    localparam int POOL_SIZE   = 80;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 60;
    localparam int FILL_ITEMS  = 70;
    localparam int ITEM_CYCLES = lcct_pkg::ROWS + 4;

    typedef struct packed {
        logic [lcct_pkg::KIND_W-1:0]   kind;
        logic [lcct_pkg::NUMBER_W-1:0] num;
        logic [lcct_pkg::COUNT_W-1:0]  val;
    } t_cmd;

    typedef struct packed {
        logic                          hit;
        logic [lcct_pkg::STATUS_W-1:0] status;
        logic [lcct_pkg::COUNT_W-1:0]  count;
        logic                          cand_v;
        logic [lcct_pkg::NUMBER_W-1:0] cand_n;
    } t_reply;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [lcct_pkg::KIND_W-1:0]   i_kind;
    logic [lcct_pkg::NUMBER_W-1:0] i_log_number;
    logic [lcct_pkg::COUNT_W-1:0]  i_count_value;
    logic                          o_done;
    logic                          o_hit;
    logic [lcct_pkg::STATUS_W-1:0] o_status;
    logic [lcct_pkg::COUNT_W-1:0]  o_drop_count;
    logic                          o_candidate_valid;
    logic [lcct_pkg::NUMBER_W-1:0] o_candidate_number;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [lcct_pkg::PADDR_W-1:0]  paddr;
    logic [lcct_pkg::PDATA_W-1:0]  pwdata;
    logic [lcct_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    log_cleaning_candidate_table i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_kind             (i_kind),
        .i_log_number       (i_log_number),
        .i_count_value      (i_count_value),
        .o_done             (o_done),
        .o_hit              (o_hit),
        .o_status           (o_status),
        .o_drop_count       (o_drop_count),
        .o_candidate_valid  (o_candidate_valid),
        .o_candidate_number (o_candidate_number),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // table model
    logic                                 tbl_valid  [lcct_pkg::TABLE_ENTRIES];
    logic [lcct_pkg::LOG_NUMBER_BITS-1:0] tbl_num    [lcct_pkg::TABLE_ENTRIES];
    logic [lcct_pkg::COUNT_W-1:0]         tbl_count  [lcct_pkg::TABLE_ENTRIES];
    logic                                 tbl_marked [lcct_pkg::TABLE_ENTRIES];
    logic [lcct_pkg::LOG_NUMBER_BITS-1:0] cur_log;
    logic [lcct_pkg::COUNT_W-1:0]         threshold;

    t_cmd                          pending_cmds [$];
    t_reply                        expected_replies [$];
    t_cmd                          drive_cmd;
    t_reply                        want;
    logic [lcct_pkg::NUMBER_W-1:0] log_pool [POOL_SIZE];
    logic                          taken;
    int                            idle_pct;
    int                            fails;

    function automatic t_reply predict_table_op(t_cmd c);
        t_reply                               r;
        int                                   s;
        int                                   f;
        logic [lcct_pkg::LOG_NUMBER_BITS-1:0] n;
        n = c.num[lcct_pkg::LOG_NUMBER_BITS-1:0];
        r = '0;
        s = -1;
        f = -1;
        for (int i = 0; i < lcct_pkg::TABLE_ENTRIES; i++) begin
            if (s < 0 && tbl_valid[i] && tbl_num[i] == n) s = i;
            if (f < 0 && !tbl_valid[i]) f = i;
        end
        r.hit = (s >= 0);
        case (c.kind)
            lcct_pkg::KIND_ADD: begin
                if (s >= 0) begin
                    r.status = lcct_pkg::ST_DUPLICATE;
                    r.count  = tbl_count[s];
                end else if (f < 0) begin
                    r.status = lcct_pkg::ST_FULL;
                end else begin
                    tbl_valid[f]  = 1'b1;
                    tbl_num[f]    = n;
                    tbl_count[f]  = '0;
                    tbl_marked[f] = 1'b0;
                    cur_log       = n;
                end
            end
            lcct_pkg::KIND_SET_CUR: begin
                cur_log = n;
                if (s >= 0) r.count = tbl_count[s];
            end
            lcct_pkg::KIND_DROP, lcct_pkg::KIND_RESTORE: begin
                if (s < 0) begin
                    r.status = lcct_pkg::ST_NOT_FOUND;
                end else begin
                    if (c.kind == lcct_pkg::KIND_RESTORE) tbl_count[s] = c.val;
                    else if (tbl_count[s] != lcct_pkg::COUNT_MAX)
                        tbl_count[s] = tbl_count[s] + 1'b1;
                    // mark is sticky: only remove clears it
                    if (tbl_count[s] >= threshold && tbl_num[s] != cur_log)
                        tbl_marked[s] = 1'b1;
                    r.count = tbl_count[s];
                end
            end
            lcct_pkg::KIND_REMOVE: begin
                if (s < 0) begin
                    r.status = lcct_pkg::ST_NOT_FOUND;
                end else begin
                    tbl_valid[s]  = 1'b0;
                    tbl_marked[s] = 1'b0;
                end
            end
            default: begin
                if (s < 0) r.status = lcct_pkg::ST_NOT_FOUND;
                else r.count = tbl_count[s];
            end
        endcase
        for (int i = 0; i < lcct_pkg::TABLE_ENTRIES; i++) begin
            if (!r.cand_v && tbl_valid[i] && tbl_marked[i]) begin
                r.cand_v = 1'b1;
                r.cand_n = lcct_pkg::NUMBER_W'(tbl_num[i]);
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got);
        if (got !== exp_v) begin
            fails++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, name, exp_v, got);
        end
    endtask

    task automatic add_cmd(input logic [lcct_pkg::KIND_W-1:0] k,
                           input logic [lcct_pkg::NUMBER_W-1:0] n,
                           input logic [lcct_pkg::COUNT_W-1:0] v);
        pending_cmds.push_back(t_cmd'{k, n, v});
    endtask

    task automatic push_random_cmd();
        logic [lcct_pkg::KIND_W-1:0]   k;
        logic [lcct_pkg::NUMBER_W-1:0] n;
        logic [lcct_pkg::COUNT_W-1:0]  v;
        int                            pick;
        pick = $urandom_range(99);
        if (pick < 22) k = lcct_pkg::KIND_ADD;
        else if (pick < 32) k = lcct_pkg::KIND_SET_CUR;
        else if (pick < 56) k = lcct_pkg::KIND_DROP;
        else if (pick < 70) k = lcct_pkg::KIND_RESTORE;
        else if (pick < 85) k = lcct_pkg::KIND_REMOVE;
        else if (pick < 95) k = KIND_LOOKUP;
        else if (pick < 98) k = KIND_SPARE_LO;
        else k = KIND_SPARE_HI;
        // mostly numbers from the pool so that entries are hit; the rest is noise
        if ($urandom_range(9) == 0) n = lcct_pkg::NUMBER_W'($urandom);
        else n = log_pool[$urandom_range(POOL_SIZE - 1)];
        case ($urandom_range(4))
            0: v = lcct_pkg::COUNT_W'({$urandom, $urandom});
            1: v = threshold - 1'b1;
            2: v = threshold;
            3: v = lcct_pkg::COUNT_MAX;
            default: v = lcct_pkg::COUNT_W'($urandom_range(3));
        endcase
        add_cmd(k, n, v);
    endtask

    task automatic write_threshold(input logic [lcct_pkg::COUNT_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESHOLD_ADDR;
        pwdata  <= {(lcct_pkg::PDATA_W - lcct_pkg::COUNT_W)'($urandom), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        threshold = value;
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || start || expected_replies.size() != 0)
            @(negedge i_clk);
        repeat (ITEM_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("log_cleaning_candidate_table regression: fail");
        $finish;
    end

    // driver: new item offered at the falling edge once the previous one is taken
    always @(negedge i_clk) begin
        if (!start || taken) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
                drive_cmd = pending_cmds.pop_front();
                start         <= 1'b1;
                i_kind        <= drive_cmd.kind;
                i_log_number  <= drive_cmd.num;
                i_count_value <= drive_cmd.val;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        taken = i_rst_n && start && !busy;
        if (i_rst_n && o_done) begin
            if (expected_replies.size() == 0) begin
                fails++;
                $display("%0t: unexpected result: expected none, actual hit %0h status %0h %s %0h",
                         $realtime, o_hit, o_status, "count", o_drop_count);
            end else begin
                want = expected_replies.pop_front();
                check_field("hit", 64'(want.hit), 64'(o_hit));
                check_field("status", 64'(want.status), 64'(o_status));
                check_field("drop_count", 64'(want.count), 64'(o_drop_count));
                check_field("candidate_valid", 64'(want.cand_v), 64'(o_candidate_valid));
                check_field("candidate_number", 64'(want.cand_n), 64'(o_candidate_number));
            end
        end
        if (taken)
            expected_replies.push_back(
                predict_table_op(t_cmd'{i_kind, i_log_number, i_count_value}));
    end

    initial begin
        logic [lcct_pkg::COUNT_W-1:0] phase_thr [PHASES];
        int                           phase_idle [PHASES];
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_kind        = lcct_pkg::KIND_ADD;
        i_log_number  = '0;
        i_count_value = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        taken         = 1'b0;
        idle_pct      = 0;
        fails         = 0;
        for (int i = 0; i < lcct_pkg::TABLE_ENTRIES; i++) begin
            tbl_valid[i]  = 1'b0;
            tbl_num[i]    = '0;
            tbl_count[i]  = '0;
            tbl_marked[i] = 1'b0;
        end
        cur_log   = '0;
        threshold = lcct_pkg::THRESHOLD_RESET;
        for (int i = 0; i < POOL_SIZE; i++) log_pool[i] = lcct_pkg::NUMBER_W'($urandom);
        log_pool[0] = '0;
        log_pool[1] = '1;
        phase_thr  = '{lcct_pkg::COUNT_W'(1), lcct_pkg::COUNT_MAX, lcct_pkg::COUNT_W'(0),
                       lcct_pkg::COUNT_W'(3), lcct_pkg::COUNT_W'({$urandom, $urandom}),
                       lcct_pkg::COUNT_W'(2)};
        phase_idle = '{0, 52, 0, 36, 52, 36};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset threshold of one
        add_cmd(KIND_LOOKUP, 16'h0000, '0);
        add_cmd(lcct_pkg::KIND_DROP, 16'hFFFF, '0);
        add_cmd(lcct_pkg::KIND_RESTORE, 16'hFFFF, lcct_pkg::COUNT_MAX);
        add_cmd(lcct_pkg::KIND_REMOVE, 16'h0000, '0);
        add_cmd(lcct_pkg::KIND_ADD, 16'h0000, lcct_pkg::COUNT_MAX);
        add_cmd(lcct_pkg::KIND_ADD, 16'h0000, '0);
        add_cmd(lcct_pkg::KIND_DROP, 16'h0000, '0);
        add_cmd(lcct_pkg::KIND_ADD, 16'hFFFF, '0);
        add_cmd(lcct_pkg::KIND_DROP, 16'h0000, '0);
        add_cmd(lcct_pkg::KIND_RESTORE, 16'h0000, '0);
        add_cmd(lcct_pkg::KIND_SET_CUR, 16'h0000, '0);
        add_cmd(lcct_pkg::KIND_SET_CUR, 16'h1234, '0);
        add_cmd(lcct_pkg::KIND_RESTORE, 16'hFFFF, lcct_pkg::COUNT_MAX);
        add_cmd(lcct_pkg::KIND_DROP, 16'hFFFF, '0);
        add_cmd(KIND_LOOKUP, 16'hFFFF, '0);
        add_cmd(KIND_SPARE_LO, 16'hFFFF, '0);
        add_cmd(KIND_SPARE_HI, 16'h1234, '0);
        add_cmd(lcct_pkg::KIND_REMOVE, 16'h0000, '0);
        add_cmd(lcct_pkg::KIND_REMOVE, 16'hFFFF, '0);
        add_cmd(lcct_pkg::KIND_ADD, 16'h5A5A, '0);
        add_cmd(lcct_pkg::KIND_RESTORE, 16'h5A5A, 48'hAAAA_AAAA_AAAA);
        add_cmd(lcct_pkg::KIND_RESTORE, 16'h5A5A, 48'h5555_5555_5555);
        add_cmd(lcct_pkg::KIND_SET_CUR, 16'hA5A5, '0);
        add_cmd(lcct_pkg::KIND_DROP, 16'h5A5A, '0);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            write_threshold(phase_thr[p]);
            idle_pct = phase_idle[p];
            // fill past capacity so that adds hit a full table
            if (p == 1 || p == 4) begin
                for (int i = 0; i < FILL_ITEMS; i++)
                    add_cmd(lcct_pkg::KIND_ADD, log_pool[i],
                            lcct_pkg::COUNT_W'({$urandom, $urandom}));
            end
            for (int i = 0; i < PHASE_ITEMS; i++) push_random_cmd();
            wait_drained();
        end

        if (fails == 0) $display("log_cleaning_candidate_table regression: pass");
        else $display("log_cleaning_candidate_table regression: fail");
        $finish;
    end

endmodule
